>>> rtl/core/gha_pkg.sv
// shared constants and types for the generational handle allocator
package gha_pkg;
  localparam int INDEX_BITS     = 10;
  localparam int VERSION_BITS   = 8;
  localparam int NUM_COMPONENTS = 64;
  localparam int TABLE_SIZE     = 1 << INDEX_BITS;
  localparam int HANDLE_BITS    = INDEX_BITS + VERSION_BITS;
  localparam int COUNT_BITS     = INDEX_BITS + 1;
  localparam int COMP_BITS      = 6;

  typedef logic [INDEX_BITS-1:0]     index_t;
  typedef logic [VERSION_BITS-1:0]   version_t;
  typedef logic [HANDLE_BITS-1:0]    handle_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [NUM_COMPONENTS-1:0] mask_t;

  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_DESTROY = 3'd1;
  localparam logic [2:0] REQ_ADD     = 3'd2;
  localparam logic [2:0] REQ_REMOVE  = 3'd3;
  localparam logic [2:0] REQ_HAS     = 3'd4;
  localparam logic [2:0] REQ_CHECK   = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_HAS     = 3'd2;
  localparam logic [2:0] ST_LACKS   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // one slot entry: alive bit, version and component mask
  typedef struct packed {
    logic     alive;
    version_t version;
    mask_t    mask;
  } entry_t;

  // write port of a memory
  typedef struct packed {
    logic   en;
    index_t addr;
    entry_t data;
  } slot_wr_t;
endpackage

>>> rtl/core/gha_slot_mem.sv
// slot table memory: alive bit, version and component mask per slot, registered read
module gha_slot_mem (
  input  logic            clk,
  input  gha_pkg::index_t rd_addr,
  output gha_pkg::entry_t rd_data,
  input  gha_pkg::slot_wr_t wr
);
  import gha_pkg::*;

  entry_t mem [TABLE_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

>>> rtl/core/gha_stack_mem.sv
// free slot stack memory, registered read
module gha_stack_mem (
  input  logic            clk,
  input  gha_pkg::index_t rd_addr,
  output gha_pkg::index_t rd_data,
  input  logic            wr_en,
  input  gha_pkg::index_t wr_addr,
  input  gha_pkg::index_t wr_data
);
  import gha_pkg::*;

  index_t mem [TABLE_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

>>> rtl/core/generational_handle_allocator.sv
// top level of the generational handle allocator
//
// Command port: a request beat (req_type, handle, component) is taken at a
// clock edge with start high and busy low. Every request gives exactly one
// result beat, shown for one cycle with done high: ok, status, new_handle,
// slot, live_count and used_count.
// Sequence: a request is latched in S_IDLE, both memories are read in
// S_READ, and in S_EXEC the block decides, writes back and registers the
// result. busy is high in S_READ and S_EXEC, so no new request is taken
// until the current one has been executed. This is set by the
// read-modify-write of the slot memory and the free stack.
// A create pops the free stack when it is not empty and bumps the slot's
// version, else appends a fresh slot (version 0, empty mask) while the table has room.
// Alive bits sit in the slot memory next to the version; a slot at or above
// the used count is never valid, so reset clears the counts, state and results,
// and the memories need no clearing pass. The block accepts requests in the cycle
// after reset is released.
// The receiver cannot stall: done is a one-cycle strobe.
module generational_handle_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  gha_pkg::handle_t            handle,
  input  logic [gha_pkg::COMP_BITS-1:0] component,
  output logic                        done,
  output logic                        ok,
  output logic [2:0]                  status,
  output gha_pkg::handle_t            new_handle,
  output gha_pkg::index_t             slot,
  output gha_pkg::count_t             live_count,
  output gha_pkg::count_t             used_count
);
  import gha_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC} state_t;

  state_t     state;
  logic [2:0] req;
  handle_t    hreg;
  logic [COMP_BITS-1:0] comp;
  count_t     free_count;
  count_t     slots_used;

  entry_t   ent;
  index_t   pop_slot;
  slot_wr_t wr;
  logic     stk_we;
  index_t   rd_addr;
  index_t   stk_rd_addr;
  count_t   free_dec;

  // read addresses: slot memory by popped slot or handle index, stack by top of stack
  assign free_dec    = free_count - 1'b1;
  assign rd_addr     = (req == REQ_CREATE) ? pop_slot : hreg[INDEX_BITS-1:0];
  assign stk_rd_addr = free_dec[INDEX_BITS-1:0];

  gha_slot_mem u_slot (
    .clk, .rd_addr(rd_addr),
    .rd_data(ent), .wr
  );

  gha_stack_mem u_stack (
    .clk, .rd_addr(stk_rd_addr), .rd_data(pop_slot),
    .wr_en(stk_we), .wr_addr(free_count[INDEX_BITS-1:0]),
    .wr_data(hreg[INDEX_BITS-1:0])
  );

  // decode of the latched request against the read entry
  index_t   idx;
  version_t ver;
  logic     valid, comp_ok, has, pop, grow;
  mask_t    bit_m;
  entry_t   reused;

  always_comb begin
    idx     = hreg[INDEX_BITS-1:0];
    ver     = hreg[HANDLE_BITS-1:INDEX_BITS];
    valid   = (hreg != {HANDLE_BITS{1'b1}}) && ({1'b0, idx} < slots_used) &&
              ent.alive && (ent.version == ver);
    comp_ok = {1'b0, comp} < (COMP_BITS+1)'(NUM_COMPONENTS);
    bit_m   = mask_t'(1) << comp;
    has     = valid && comp_ok && ((ent.mask & bit_m) != '0);
    pop     = (req == REQ_CREATE) && (free_count != '0);
    grow    = (req == REQ_CREATE) && (free_count == '0) &&
              (slots_used < count_t'(TABLE_SIZE));
    reused  = ent;
    reused.alive   = 1'b1;
    reused.version = ent.version + 1'b1;
  end

  // memory write-back in the execute cycle
  always_comb begin
    wr     = '0;
    stk_we = 1'b0;
    if (state == S_EXEC) begin
      case (req)
        REQ_CREATE: begin
          if (pop) begin
            wr.en = 1'b1; wr.addr = pop_slot; wr.data = reused;
          end else if (grow) begin
            wr.en = 1'b1; wr.addr = slots_used[INDEX_BITS-1:0]; wr.data = '0;
            wr.data.alive = 1'b1;
          end
        end
        REQ_DESTROY: begin
          if (valid) begin
            wr.en = 1'b1; wr.addr = idx; wr.data = ent;
            wr.data.alive = 1'b0; wr.data.mask = '0;
            stk_we = 1'b1;
          end
        end
        REQ_ADD: begin
          if (valid && comp_ok && !has) begin
            wr.en = 1'b1; wr.addr = idx; wr.data = ent;
            wr.data.mask = ent.mask | bit_m;
          end
        end
        REQ_REMOVE: begin
          if (has) begin
            wr.en = 1'b1; wr.addr = idx; wr.data = ent;
            wr.data.mask = ent.mask & ~bit_m;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // sequencer, counts and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      free_count <= '0;
      slots_used <= '0;
      ok         <= 1'b0;
      status     <= ST_OK;
      new_handle <= '0;
      slot       <= '0;
      live_count <= '0;
      used_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= req_type;
            hreg  <= handle;
            comp  <= component;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          ok         <= 1'b0;
          status     <= ST_INVALID;
          new_handle <= '0;
          slot       <= idx;
          live_count <= slots_used - free_count;
          used_count <= slots_used;
          case (req)
            REQ_CREATE: begin
              slot <= '0;
              if (pop) begin
                free_count  <= free_dec;
                slot        <= pop_slot;
                new_handle  <= {reused.version, pop_slot};
                ok <= 1'b1; status <= ST_OK;
                live_count  <= slots_used - free_dec;
              end else if (grow) begin
                slots_used  <= slots_used + 1'b1;
                slot        <= slots_used[INDEX_BITS-1:0];
                new_handle  <= {version_t'(0), slots_used[INDEX_BITS-1:0]};
                ok <= 1'b1; status <= ST_OK;
                live_count  <= slots_used + 1'b1 - free_count;
                used_count  <= slots_used + 1'b1;
              end else begin
                status <= ST_FULL;
              end
            end
            REQ_DESTROY: begin
              if (valid) begin
                free_count <= free_count + 1'b1;
                live_count <= slots_used - free_count - 1'b1;
                ok <= 1'b1; status <= ST_OK;
              end
            end
            REQ_ADD: begin
              if (valid && comp_ok) begin
                ok     <= !has;
                status <= has ? ST_HAS : ST_OK;
              end
            end
            REQ_REMOVE, REQ_HAS: begin
              if (valid) begin
                ok     <= has;
                status <= has ? ST_OK : ST_LACKS;
              end
            end
            REQ_CHECK: begin
              if (valid) begin
                ok <= 1'b1; status <= ST_OK;
              end
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> verif/generational_handle_allocator_test.sv
// self-checking testbench for the generational handle allocator
module generational_handle_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gha_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [2:0] REQ_BAD6 = 3'd6;
  localparam logic [2:0] REQ_BAD7 = 3'd7;
  localparam handle_t ALL_ONES = '1;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    handle_t    new_handle;
    index_t     slot;
    count_t     live;
    count_t     used;
  } answer_t;

  // directed row: typed-in answer used only where has_ans is set
  typedef struct {
    logic [2:0] req;
    handle_t    h;
    logic [5:0] comp;
    bit         has_ans;
    logic       ok;
    logic [2:0] status;
    handle_t    new_handle;
    index_t     slot;
  } row_t;

  logic clk, rst, start, busy, done, ok;
  logic [2:0] req_type, status;
  handle_t handle, new_handle;
  logic [COMP_BITS-1:0] component;
  index_t slot;
  count_t live_count, used_count;

  generational_handle_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .handle(handle), .component(component),
    .done(done), .ok(ok), .status(status), .new_handle(new_handle),
    .slot(slot), .live_count(live_count), .used_count(used_count)
  );

  // shadow copy of the slot table
  version_t tbl_version [TABLE_SIZE];
  logic     tbl_alive   [TABLE_SIZE];
  mask_t    tbl_mask    [TABLE_SIZE];
  index_t   free_slots  [TABLE_SIZE];
  count_t   free_depth;
  count_t   slots_used;

  answer_t pending_answers[$];
  handle_t live_handles[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit handle_alive(input handle_t h);
    index_t idx = h[INDEX_BITS-1:0];
    if (h == ALL_ONES) return 0;
    if (idx >= slots_used || !tbl_alive[idx]) return 0;
    return tbl_version[idx] == h[HANDLE_BITS-1:INDEX_BITS];
  endfunction

  // compute the answer to one request and update the shadow table
  function automatic answer_t apply_request(input logic [2:0] req, input handle_t h,
                                            input logic [5:0] comp);
    answer_t a;
    index_t idx = h[INDEX_BITS-1:0];
    index_t s;
    bit valid = handle_alive(h);
    bit has = valid && tbl_mask[idx][comp];
    a = '0;
    a.status = ST_INVALID;
    a.slot = idx;
    case (req)
      REQ_CREATE: begin
        a.slot = '0;
        if (free_depth > 0) begin
          free_depth--;
          s = free_slots[free_depth[INDEX_BITS-1:0]];
          tbl_version[s] = tbl_version[s] + 1'b1;
          tbl_alive[s] = 1;
        end else if (slots_used < TABLE_SIZE) begin
          s = slots_used[INDEX_BITS-1:0];
          slots_used++;
          tbl_version[s] = '0;
          tbl_mask[s] = '0;
          tbl_alive[s] = 1;
        end else begin
          a.status = ST_FULL;
        end
        if (a.status != ST_FULL) begin
          a.slot = s;
          a.new_handle = {tbl_version[s], s};
          a.ok = 1;
          a.status = ST_OK;
        end
      end
      REQ_DESTROY: begin
        if (valid) begin
          tbl_alive[idx] = 0;
          tbl_mask[idx] = '0;
          free_slots[free_depth[INDEX_BITS-1:0]] = idx;
          free_depth++;
          a.ok = 1;
          a.status = ST_OK;
        end
      end
      REQ_ADD: begin
        if (valid && has) a.status = ST_HAS;
        else if (valid) begin
          tbl_mask[idx][comp] = 1;
          a.ok = 1;
          a.status = ST_OK;
        end
      end
      REQ_REMOVE: begin
        if (valid && has) begin
          tbl_mask[idx][comp] = 0;
          a.ok = 1;
          a.status = ST_OK;
        end else if (valid) a.status = ST_LACKS;
      end
      REQ_HAS: begin
        if (valid) begin
          a.ok = has;
          a.status = has ? ST_OK : ST_LACKS;
        end
      end
      REQ_CHECK: begin
        if (valid) begin
          a.ok = 1;
          a.status = ST_OK;
        end
      end
      default: ;
    endcase
    a.used = slots_used;
    a.live = slots_used - free_depth;
    return a;
  endfunction

  // drive one request beat and record its answer once accepted
  task automatic issue(input logic [2:0] req, input handle_t h, input logic [5:0] comp,
                       input bit typed = 0, input answer_t typed_ans = '0);
    answer_t a;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    req_type <= req;
    handle <= h;
    component <= comp;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = apply_request(req, h, comp);
    if (typed) begin
      a.ok = typed_ans.ok;
      a.status = typed_ans.status;
      a.new_handle = typed_ans.new_handle;
      a.slot = typed_ans.slot;
    end
    pending_answers.push_back(a);
    // keep the pool of live handles current
    if (req == REQ_CREATE && a.ok && a.new_handle != ALL_ONES)
      live_handles.push_back(a.new_handle);
    if (req == REQ_DESTROY && a.ok) begin
      foreach (live_handles[i])
        if (live_handles[i] == h) begin
          live_handles.delete(i);
          break;
        end
    end
  endtask

  // pick a handle: mostly live, sometimes stale or random
  function automatic handle_t pick_handle();
    handle_t h;
    int r = $urandom_range(99);
    if (live_handles.size() == 0 || r < 10) return handle_t'($urandom_range(262143));
    h = live_handles[$urandom_range(live_handles.size() - 1)];
    if (r < 18) h[HANDLE_BITS-1:INDEX_BITS] = h[HANDLE_BITS-1:INDEX_BITS] + 1'b1;
    return h;
  endfunction

  task automatic random_beats(input int n);
    int r;
    logic [2:0] req;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 22 || live_handles.size() < 4) req = REQ_CREATE;
      else if (r < 34) req = REQ_DESTROY;
      else if (r < 56) req = REQ_ADD;
      else if (r < 71) req = REQ_REMOVE;
      else if (r < 86) req = REQ_HAS;
      else if (r < 96) req = REQ_CHECK;
      else req = r[0] ? REQ_BAD6 : REQ_BAD7;
      issue(req, pick_handle(), 6'($urandom_range(63)));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("mismatch: result beat with nothing expected at %0t", $realtime);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (new_handle !== want.new_handle)
          report_mismatch("new_handle", new_handle, want.new_handle);
        if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
        if (live_count !== want.live) report_mismatch("live_count", live_count, want.live);
        if (used_count !== want.used) report_mismatch("used_count", used_count, want.used);
      end
    end
  end

  row_t rows[$];
  answer_t typed;

  initial begin
    rst = 1;
    start = 0;
    req_type = REQ_CREATE;
    handle = '0;
    component = '0;
    free_depth = '0;
    slots_used = '0;
    foreach (tbl_alive[i]) tbl_alive[i] = 0;

    // directed stimulus
    rows = '{
      '{REQ_CHECK,   18'h00000,  6'd0, 1, 0, ST_INVALID, '0, 10'd0},
      '{REQ_CREATE,  18'h3ffff,  6'd63, 1, 1, ST_OK, 18'h00000, 10'd0},
      '{REQ_CHECK,   18'h00000,  6'd0, 1, 1, ST_OK, '0, 10'd0},
      '{REQ_ADD,     18'h00000,  6'd0, 1, 1, ST_OK, '0, 10'd0},
      '{REQ_ADD,     18'h00000,  6'd0, 1, 0, ST_HAS, '0, 10'd0},
      '{REQ_ADD,     18'h00000,  6'd63, 1, 1, ST_OK, '0, 10'd0},
      '{REQ_HAS,     18'h00000,  6'd63, 1, 1, ST_OK, '0, 10'd0},
      '{REQ_REMOVE,  18'h00000,  6'd63, 1, 1, ST_OK, '0, 10'd0},
      '{REQ_REMOVE,  18'h00000,  6'd63, 1, 0, ST_LACKS, '0, 10'd0},
      '{REQ_HAS,     18'h00000,  6'd5, 1, 0, ST_LACKS, '0, 10'd0},
      '{REQ_CHECK,   18'h3ffff,  6'd0, 1, 0, ST_INVALID, '0, 10'd1023},
      '{REQ_CHECK,   18'h00400,  6'd0, 1, 0, ST_INVALID, '0, 10'd0},
      '{REQ_BAD6,    18'h00000,  6'd0, 1, 0, ST_INVALID, '0, 10'd0},
      '{REQ_BAD7,    18'h2aa55,  6'd42, 1, 0, ST_INVALID, '0, 10'h255},
      '{REQ_DESTROY, 18'h00000,  6'd0, 1, 1, ST_OK, '0, 10'd0},
      '{REQ_DESTROY, 18'h00000,  6'd0, 1, 0, ST_INVALID, '0, 10'd0},
      '{REQ_CREATE,  18'h00000,  6'd0, 1, 1, ST_OK, 18'h00400, 10'd0},
      '{REQ_HAS,     18'h00400,  6'd0, 1, 0, ST_LACKS, '0, 10'd0},
      '{REQ_CREATE,  18'h15555,  6'd21, 1, 1, ST_OK, 18'h00001, 10'd1},
      '{REQ_ADD,     18'h00001,  6'd31, 0, 0, 0, '0, '0},
      '{REQ_ADD,     18'h3fc01,  6'd1, 1, 0, ST_INVALID, '0, 10'd1},
      '{REQ_REMOVE,  18'h00005,  6'd1, 1, 0, ST_INVALID, '0, 10'd5},
      '{REQ_HAS,     18'h00000,  6'd1, 1, 0, ST_INVALID, '0, 10'd0},
      '{REQ_DESTROY, 18'h003ff,  6'd0, 1, 0, ST_INVALID, '0, 10'd1023},
      '{REQ_DESTROY, 18'h00001,  6'd0, 0, 0, 0, '0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 0;

    foreach (rows[i]) begin
      typed = '0;
      typed.ok = rows[i].ok;
      typed.status = rows[i].status;
      typed.new_handle = rows[i].new_handle;
      typed.slot = rows[i].slot;
      issue(rows[i].req, rows[i].h, rows[i].comp, rows[i].has_ans, typed);
    end

    // random traffic in three idling phases
    idle_pct = 11;
    random_beats(180);
    idle_pct = 78;
    random_beats(180);

    // hold off until the block has drained
    start <= 0;
    while (pending_answers.size() != 0) @(posedge clk);

    idle_pct = 0;
    random_beats(190);

    // fill the table, hit the full case, then drive the last slot's version up to all ones
    while (slots_used < TABLE_SIZE || free_depth > 0)
      issue(REQ_CREATE, handle_t'($urandom_range(262143)), 6'($urandom_range(63)));
    issue(REQ_CREATE, '0, '0);
    issue(REQ_CHECK, {tbl_version[TABLE_SIZE-1], index_t'(TABLE_SIZE-1)}, '0);
    while (tbl_version[TABLE_SIZE-1] != '1) begin
      issue(REQ_DESTROY, {tbl_version[TABLE_SIZE-1], index_t'(TABLE_SIZE-1)},
            6'($urandom_range(63)));
      issue(REQ_CREATE, '0, '0);
    end
    issue(REQ_CHECK, ALL_ONES, '0);
    issue(REQ_DESTROY, ALL_ONES, '0);
    issue(REQ_ADD, ALL_ONES, 6'd7);
    random_beats(20);

    start <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
